[src/ewl_pkg.sv]
`timescale 1ns / 1ps
package ewl_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int ED_W      = 32;
	localparam int ADDR_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CNT_CFG_W = 5;

	localparam logic [ED_W-1:0] EMPTY_MARK = '1;

	typedef enum logic [2:0] {
		CMD_LOAD      = 3'd0,
		CMD_WRITE     = 3'd1,
		CMD_FIND      = 3'd2,
		CMD_ROLLBACK  = 3'd3,
		CMD_ERASE     = 3'd4,
		CMD_ERASE_ALL = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_SLOT_COUNT    = 2'd0,
		CFG_SLOT_STRIDE   = 2'd1,
		CFG_RECORD_LENGTH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_CFG_W-1:0] slot_count;
		logic [ADDR_W-1:0]    slot_stride;
		logic [ADDR_W-1:0]    record_length;
	} cfg_t;

	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic [ED_W-1:0]   wr_data;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              clr_en;
		logic [CNT_W-1:0]  clr_n;
	} tbl_req_t;

endpackage

[src/ewl_req_if.sv]
`timescale 1ns / 1ps
interface ewl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [3:0]  slot_index;
	logic        header_valid;
	logic [31:0] header_edition;
	logic        write_anyway;
	logic        data_changed;

	modport source (
		output valid, cmd, slot_index, header_valid, header_edition, write_anyway,
			data_changed,
		input ready
	);
	modport sink (
		input valid, cmd, slot_index, header_valid, header_edition, write_anyway,
			data_changed,
		output ready
	);
endinterface

[src/ewl_rsp_if.sv]
`timescale 1ns / 1ps
interface ewl_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        found;
	logic [3:0]  slot_out;
	logic [15:0] slot_address;
	logic [31:0] edition_out;
	logic        wrote;

	modport source (
		output valid, status, found, slot_out, slot_address, edition_out, wrote,
		input ready
	);
	modport sink (
		input valid, status, found, slot_out, slot_address, edition_out, wrote,
		output ready
	);
endinterface

[src/ewl_table.sv]
`timescale 1ns / 1ps
module ewl_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ewl_pkg::tbl_req_t            req,
	output logic [ewl_pkg::ED_W-1:0]     rd_data
);
	import ewl_pkg::*;

	logic [ED_W-1:0]      mem_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] vld_q;
	logic [ED_W-1:0]      rd_raw_q;
	logic                 rd_hit_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem_q[req.rd_addr];
		end
	end

	// entries never written since reset, or since an erase-all that cleared them, read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_hit_q <= vld_q[req.rd_addr];
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (req.clr_en && (CNT_W'(i) < req.clr_n)) begin
					vld_q[i] <= 1'b0;
				end
			end
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_raw_q : EMPTY_MARK;

endmodule

[src/ewl_seq.sv]
`timescale 1ns / 1ps
module ewl_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ewl_pkg::cfg_t            cfg,
	output ewl_pkg::tbl_req_t        tbl,
	input  logic [ewl_pkg::ED_W-1:0] rd_data,
	ewl_req_if.sink                  req,
	ewl_rsp_if.source                rsp
);
	import ewl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_COMMIT,
		ST_FIN
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [SLOT_W-1:0]   idx_q;
	logic                hvalid_q;
	logic [ED_W-1:0]     hed_q;
	logic                force_q;
	logic                changed_q;
	logic [CNT_W-1:0]    n_q;
	logic                bug_q;
	logic [ED_W-1:0]     cur_q;
	logic [ED_W-1:0]     best_q;
	logic [SLOT_W-1:0]   where_q;
	logic                hit_q;
	logic                pass_q;
	logic [CNT_W-1:0]    ptr_q;
	logic                rd_vld_s1;
	logic [SLOT_W-1:0]   rd_idx_s1;

	logic                st_q;
	logic                fnd_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ED_W-1:0]     ed_q;
	logic                wr_q;

	logic                out_valid_q;
	logic                out_status_q;
	logic                out_found_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [ED_W-1:0]     out_ed_q;
	logic                out_wrote_q;

	logic [CNT_W-1:0]         n_c;
	logic [SLOT_W+ADDR_W-1:0] prod_c;
	logic [ADDR_W-1:0]        addr_c;

	always_comb begin
		if (cfg.slot_count == '0) begin
			n_c = CNT_W'(1);
		end else if (CNT_W'(cfg.slot_count) > CNT_W'(NUM_SLOTS)) begin
			n_c = CNT_W'(NUM_SLOTS);
		end else begin
			n_c = CNT_W'(cfg.slot_count);
		end
	end

	assign prod_c = (SLOT_W+ADDR_W)'(slot_q) * (SLOT_W+ADDR_W)'(cfg.slot_stride);
	assign addr_c = (n_q == CNT_W'(1)) ? '0 : prod_c[ADDR_W-1:0];

	always_comb begin
		tbl = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (cmd_q == CMD_LOAD || cmd_q == CMD_ERASE) begin
					tbl.wr_en   = 1'b1;
					tbl.wr_addr = idx_q;
					tbl.wr_data = (cmd_q == CMD_LOAD && hvalid_q) ? hed_q : EMPTY_MARK;
				end
				if (cmd_q == CMD_ERASE_ALL && !bug_q) begin
					tbl.clr_en = 1'b1;
					tbl.clr_n  = n_q;
				end
			end
			ST_SCAN: begin
				tbl.rd_en   = ptr_q < n_q;
				tbl.rd_addr = ptr_q[SLOT_W-1:0];
			end
			ST_COMMIT: begin
				if (cmd_q == CMD_WRITE) begin
					tbl.wr_en   = 1'b1;
					tbl.wr_addr = where_q;
					tbl.wr_data = cur_q;
				end else if (cmd_q == CMD_ROLLBACK && !pass_q && best_q != '0) begin
					tbl.wr_en   = 1'b1;
					tbl.wr_addr = where_q;
					tbl.wr_data = EMPTY_MARK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= CMD_LOAD;
			idx_q        <= '0;
			hvalid_q     <= 1'b0;
			hed_q        <= '0;
			force_q      <= 1'b0;
			changed_q    <= 1'b0;
			n_q          <= CNT_W'(1);
			bug_q        <= 1'b0;
			cur_q        <= '0;
			best_q       <= '0;
			where_q      <= '0;
			hit_q        <= 1'b0;
			pass_q       <= 1'b0;
			ptr_q        <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			st_q         <= 1'b0;
			fnd_q        <= 1'b0;
			slot_q       <= '0;
			ed_q         <= '0;
			wr_q         <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_found_q  <= 1'b0;
			out_slot_q   <= '0;
			out_addr_q   <= '0;
			out_ed_q     <= '0;
			out_wrote_q  <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q     <= cmd_t'(req.cmd);
						idx_q     <= req.slot_index;
						hvalid_q  <= req.header_valid;
						hed_q     <= req.header_edition;
						force_q   <= req.write_anyway;
						changed_q <= req.data_changed;
						n_q       <= n_c;
						bug_q     <= (n_c > CNT_W'(1)) && (cfg.slot_stride < cfg.record_length);
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					st_q   <= bug_q &&
						(cmd_q inside {CMD_WRITE, CMD_FIND, CMD_ROLLBACK, CMD_ERASE_ALL});
					fnd_q  <= 1'b0;
					slot_q <= (cmd_q == CMD_LOAD || cmd_q == CMD_ERASE) ? idx_q : '0;
					ed_q   <= '0;
					wr_q   <= 1'b0;
					case (cmd_q)
						CMD_WRITE: begin
							if (!bug_q && (force_q || changed_q)) begin
								cur_q   <= cur_q + 1'b1;
								best_q  <= EMPTY_MARK;
								where_q <= '0;
								hit_q   <= 1'b0;
								ptr_q   <= '0;
								state_q <= (n_q == CNT_W'(1)) ? ST_COMMIT : ST_SCAN;
							end else begin
								state_q <= ST_FIN;
							end
						end
						CMD_FIND, CMD_ROLLBACK: begin
							if (!bug_q) begin
								best_q  <= '0;
								where_q <= '0;
								ptr_q   <= '0;
								pass_q  <= 1'b0;
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_FIN;
							end
						end
						CMD_ERASE_ALL: begin
							if (!bug_q) begin
								cur_q <= '0;
							end
							state_q <= ST_FIN;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_SCAN: begin
					rd_vld_s1 <= (ptr_q < n_q);
					if (ptr_q < n_q) begin
						ptr_q     <= ptr_q + 1'b1;
						rd_idx_s1 <= ptr_q[SLOT_W-1:0];
					end
					if (rd_vld_s1) begin
						if (cmd_q == CMD_WRITE) begin
							if (!hit_q) begin
								if (rd_data == EMPTY_MARK) begin
									hit_q   <= 1'b1;
									where_q <= rd_idx_s1;
								end else if (rd_data < best_q) begin
									best_q  <= rd_data;
									where_q <= rd_idx_s1;
								end
							end
						end else if (rd_data != EMPTY_MARK && rd_data > best_q) begin
							best_q  <= rd_data;
							where_q <= rd_idx_s1;
						end
					end
					if (ptr_q == n_q && !rd_vld_s1) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (cmd_q == CMD_WRITE) begin
						fnd_q   <= 1'b1;
						slot_q  <= where_q;
						ed_q    <= cur_q;
						wr_q    <= 1'b1;
						state_q <= ST_FIN;
					end else if (cmd_q == CMD_ROLLBACK && !pass_q) begin
						// second pass finds the latest after the removal
						pass_q  <= 1'b1;
						best_q  <= '0;
						where_q <= '0;
						ptr_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						cur_q <= best_q;
						if (best_q != '0) begin
							fnd_q  <= 1'b1;
							slot_q <= where_q;
							ed_q   <= best_q;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= st_q;
						out_found_q  <= fnd_q;
						out_slot_q   <= slot_q;
						out_addr_q   <= addr_c;
						out_ed_q     <= ed_q;
						out_wrote_q  <= wr_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.found        = out_found_q;
	assign rsp.slot_out     = out_slot_q;
	assign rsp.slot_address = out_addr_q;
	assign rsp.edition_out  = out_ed_q;
	assign rsp.wrote        = out_wrote_q;

endmodule

[src/eeprom_wear_level_slot_manager.sv]
`timescale 1ns / 1ps
// One command at a time. Load slot, erase slot, erase all, refused, unchanged-data writes
// and unknown commands do no table scan, nor does a write with one slot. Write and find
// latest scan the n slots in use, one table read a cycle. Roll back scans twice. Next
// beat taken the cycle after the result loads; a result held by the sink stalls the next one.
// Reset: all slots empty, current edition 0, slot_count = stride = length = 1.
module eeprom_wear_level_slot_manager (
	input  logic                       clk,
	input  logic                       arst_n,
	ewl_req_if.sink                    req,
	ewl_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [ewl_pkg::CFG_W-1:0]  cfg_data
);
	import ewl_pkg::*;

	cfg_t            cfg_q;
	tbl_req_t        tbl;
	logic [ED_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_count    <= CNT_CFG_W'(1);
			cfg_q.slot_stride   <= ADDR_W'(1);
			cfg_q.record_length <= ADDR_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLOT_COUNT:    cfg_q.slot_count    <= cfg_data[CNT_CFG_W-1:0];
				CFG_SLOT_STRIDE:   cfg_q.slot_stride   <= cfg_data[ADDR_W-1:0];
				CFG_RECORD_LENGTH: cfg_q.record_length <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	ewl_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.tbl     (tbl),
		.rd_data (rd_data),
		.req     (req),
		.rsp     (rsp)
	);

	ewl_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl),
		.rd_data (rd_data)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second command taken while one is in progress");

	a_none_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.edition_out == '0 && !rsp.wrote)
		else $error("edition or write reported without a slot");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> !rsp.found && rsp.slot_address == '0)
		else $error("refused command returned a slot");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
	import ewl_pkg::*;

	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int RANDOM_PER_SETTING = 88;
	localparam int CYCLE_LIMIT = 800000;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [3:0]      slot_index;
		logic            header_valid;
		logic [ED_W-1:0] header_edition;
		logic            write_anyway;
		logic            data_changed;
	} slot_cmd_t;

	typedef struct packed {
		logic              status;
		logic              found;
		logic [3:0]        slot_out;
		logic [ADDR_W-1:0] slot_address;
		logic [ED_W-1:0]   edition_out;
		logic              wrote;
	} slot_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ewl_req_if req();
	ewl_rsp_if rsp();

	eeprom_wear_level_slot_manager uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the slot table and registers
	logic [ED_W-1:0] edition_tbl [NUM_SLOTS];
	logic [ED_W-1:0] cur_edition;
	logic [CNT_CFG_W-1:0] shadow_count;
	logic [ADDR_W-1:0] shadow_stride;
	logic [ADDR_W-1:0] shadow_length;

	slot_cmd_t cmd_queue[$];
	slot_answer_t due_answers[$];
	slot_cmd_t on_bus;

	int burst_left, gap_left;
	int rx_mode, rx_left, rx_tick;
	int cmd_seen[8];
	int accepted, answers_checked, mismatches, strays, settings_run;
	int cycle_count;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout: %0d commands accepted, %0d answers still due", accepted,
				due_answers.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int unsigned slots_in_use();
		int unsigned n;
		n = shadow_count;
		if (n == 0) n = 1;
		if (n > NUM_SLOTS) n = NUM_SLOTS;
		return n;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_byte_addr(int unsigned s);
		logic [31:0] p;
		if (slots_in_use() == 1) return '0;
		p = s * shadow_stride;
		return p[ADDR_W-1:0];
	endfunction

	function automatic logic [ED_W-1:0] newest_edition(output int unsigned where);
		logic [ED_W-1:0] best;
		best = '0;
		where = 0;
		for (int unsigned i = 0; i < slots_in_use(); i++) begin
			if (edition_tbl[i] != EMPTY_MARK && edition_tbl[i] > best) begin
				best = edition_tbl[i];
				where = i;
			end
		end
		return best;
	endfunction

	function automatic int unsigned victim_slot();
		logic [ED_W-1:0] oldest;
		int unsigned pick;
		oldest = EMPTY_MARK;
		pick = 0;
		if (slots_in_use() == 1) return 0;
		for (int unsigned i = 0; i < slots_in_use(); i++) begin
			if (edition_tbl[i] == EMPTY_MARK) return i;
			if (edition_tbl[i] < oldest) begin
				oldest = edition_tbl[i];
				pick = i;
			end
		end
		return pick;
	endfunction

	function automatic slot_answer_t newest_answer();
		slot_answer_t a;
		int unsigned s;
		logic [ED_W-1:0] e;
		a = '0;
		e = newest_edition(s);
		cur_edition = e;
		if (e != 0) begin
			a.found = 1'b1;
			a.slot_out = SLOT_W'(s);
			a.slot_address = slot_byte_addr(s);
			a.edition_out = e;
		end
		return a;
	endfunction

	function automatic slot_answer_t predict_slot_answer(slot_cmd_t c);
		slot_answer_t a;
		int unsigned s;
		a = '0;
		if (c.cmd == CMD_LOAD || c.cmd == CMD_ERASE) begin
			edition_tbl[c.slot_index] = (c.cmd == CMD_LOAD && c.header_valid) ?
				c.header_edition : EMPTY_MARK;
			a.slot_out = c.slot_index;
			a.slot_address = slot_byte_addr(c.slot_index);
			return a;
		end
		if (c.cmd > CMD_ERASE_ALL) return a;
		if (slots_in_use() > 1 && shadow_stride < shadow_length) begin
			a.status = 1'b1;
			return a;
		end
		case (c.cmd)
			CMD_WRITE: begin
				if (c.write_anyway || c.data_changed) begin
					cur_edition = cur_edition + 1'b1;
					s = victim_slot();
					edition_tbl[s] = cur_edition;
					a.found = 1'b1;
					a.slot_out = SLOT_W'(s);
					a.slot_address = slot_byte_addr(s);
					a.edition_out = cur_edition;
					a.wrote = 1'b1;
				end
			end
			CMD_FIND: a = newest_answer();
			CMD_ROLLBACK: begin
				if (newest_edition(s) != 0) edition_tbl[s] = EMPTY_MARK;
				a = newest_answer();
			end
			CMD_ERASE_ALL: begin
				for (int unsigned i = 0; i < slots_in_use(); i++) edition_tbl[i] = EMPTY_MARK;
				cur_edition = '0;
			end
			default: ;
		endcase
		return a;
	endfunction

	// driver: bursts of beats separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req.valid && req.ready) begin
				due_answers.push_back(predict_slot_answer(on_bus));
				cmd_seen[on_bus.cmd]++;
				accepted++;
			end
			if (!req.valid || req.ready) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(32, 1);
					gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
				end
				if (gap_left != 0 || cmd_queue.size() == 0) begin
					if (gap_left != 0) gap_left--;
					req.valid <= 1'b0;
				end else begin
					on_bus = cmd_queue.pop_front();
					req.cmd <= on_bus.cmd;
					req.slot_index <= on_bus.slot_index;
					req.header_valid <= on_bus.header_valid;
					req.header_edition <= on_bus.header_edition;
					req.write_anyway <= on_bus.write_anyway;
					req.data_changed <= on_bus.data_changed;
					req.valid <= 1'b1;
					burst_left--;
				end
			end
		end
	end

	// monitor: checks each result beat, ready follows a changing stall pattern
	always @(posedge clk or negedge arst_n) begin
		slot_answer_t got, want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rx_mode = 0;
			rx_left = 1;
			rx_tick = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status = rsp.status;
				got.found = rsp.found;
				got.slot_out = rsp.slot_out;
				got.slot_address = rsp.slot_address;
				got.edition_out = rsp.edition_out;
				got.wrote = rsp.wrote;
				answers_checked++;
				if (due_answers.size() == 0) begin
					strays++;
					if (mismatches + strays <= 10) begin
						$write("%0t: result beat with nothing due: ", $realtime);
						$display("st=%0d fnd=%0d slot=%0d addr=%h ed=%h wr=%0d",
							got.status, got.found, got.slot_out, got.slot_address,
							got.edition_out, got.wrote);
					end
				end else begin
					want = due_answers.pop_front();
					if (got.status !== want.status || got.found !== want.found ||
							got.slot_out !== want.slot_out ||
							got.slot_address !== want.slot_address ||
							got.edition_out !== want.edition_out || got.wrote !== want.wrote) begin
						mismatches++;
						if (mismatches + strays <= 10) begin
							$write("%0t: result %0d exp ", $realtime, answers_checked);
							$display("st=%0d fnd=%0d slot=%0d addr=%h ed=%h wr=%0d",
								want.status, want.found, want.slot_out,
								want.slot_address, want.edition_out, want.wrote);
							$write("%0t: result %0d got ", $realtime, answers_checked);
							$display("st=%0d fnd=%0d slot=%0d addr=%h ed=%h wr=%0d",
								got.status, got.found, got.slot_out,
								got.slot_address, got.edition_out, got.wrote);
						end
					end
				end
			end
			rx_tick++;
			rx_left--;
			if (rx_left == 0) begin
				rx_mode = $urandom_range(3, 0);
				rx_left = $urandom_range(300, 40);
			end
			case (rx_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(1, 0) == 1);
				2: rsp.ready <= ($urandom_range(3, 0) == 0);
				default: rsp.ready <= (rx_tick % 7) < 4;
			endcase
		end
	end

	task automatic add(logic [2:0] c, logic [3:0] s, logic hv, logic [ED_W-1:0] e,
			logic fw, logic dc);
		slot_cmd_t it;
		it.cmd = c;
		it.slot_index = s;
		it.header_valid = hv;
		it.header_edition = e;
		it.write_anyway = fw;
		it.data_changed = dc;
		cmd_queue.push_back(it);
	endtask

	task automatic add_random(int count);
		slot_cmd_t it;
		int unsigned pick;
		repeat (count) begin
			it.slot_index = ($urandom_range(9, 0) < 7) ?
				4'($urandom_range(slots_in_use() - 1, 0)) : 4'($urandom_range(15, 0));
			it.header_valid = ($urandom_range(7, 0) != 0);
			case ($urandom_range(3, 0))
				0: begin
					it.header_edition = $urandom;
					if (it.header_edition == EMPTY_MARK) it.header_edition = EMPTY_MARK - 1;
				end
				1: it.header_edition = $urandom_range(32'hFFFF_FFFE, 32'hFFFF_FFF0);
				default: it.header_edition = $urandom_range(24, 0);
			endcase
			pick = $urandom_range(3, 0);
			it.write_anyway = pick[0];
			it.data_changed = pick[1];
			pick = $urandom_range(99, 0);
			if (pick < 32) begin
				it.cmd = CMD_WRITE;
				if ($urandom_range(4, 0) != 0) it.data_changed = 1'b1;
			end else if (pick < 54) it.cmd = CMD_LOAD;
			else if (pick < 68) it.cmd = CMD_FIND;
			else if (pick < 81) it.cmd = CMD_ROLLBACK;
			else if (pick < 92) it.cmd = CMD_ERASE;
			else if (pick < 96) it.cmd = CMD_ERASE_ALL;
			else it.cmd = $urandom_range(1, 0) ? CMD_SPARE_6 : CMD_SPARE_7;
			cmd_queue.push_back(it);
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (cmd_queue.size() != 0 || req.valid || due_answers.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_config(int unsigned cnt, int unsigned stride, int unsigned len);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SLOT_COUNT;
		cfg_data <= CFG_W'(cnt);
		@(posedge clk);
		cfg_index <= CFG_SLOT_STRIDE;
		cfg_data <= CFG_W'(stride);
		@(posedge clk);
		cfg_index <= CFG_RECORD_LENGTH;
		cfg_data <= CFG_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_count = CNT_CFG_W'(cnt);
		shadow_stride = ADDR_W'(stride);
		shadow_length = ADDR_W'(len);
		settings_run++;
		@(negedge clk);
	endtask

	task automatic random_setting();
		int unsigned stride;
		stride = $urandom_range(65535, 1);
		set_config($urandom_range(16, 1), stride,
			$urandom_range(1, 0) ? $urandom_range(stride, 1) : $urandom_range(65535, 1));
		add_random(RANDOM_PER_SETTING);
	endtask

	initial begin
		int failures;
		req.valid = 1'b0;
		req.cmd = '0;
		req.slot_index = '0;
		req.header_valid = 1'b0;
		req.header_edition = '0;
		req.write_anyway = 1'b0;
		req.data_changed = 1'b0;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < NUM_SLOTS; i++) edition_tbl[i] = EMPTY_MARK;
		cur_edition = '0;
		shadow_count = CNT_CFG_W'(1);
		shadow_stride = ADDR_W'(1);
		shadow_length = ADDR_W'(1);
		settings_run = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single slot at reset values: unchanged data, edition wrap, unused codes
		add(CMD_FIND, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_WRITE, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_WRITE, 4'd0, 1'b0, '0, 1'b1, 1'b0);
		add(CMD_WRITE, 4'd0, 1'b0, '0, 1'b0, 1'b1);
		add(CMD_LOAD, 4'd0, 1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0);
		add(CMD_FIND, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_WRITE, 4'd0, 1'b0, '0, 1'b1, 1'b1);
		add(CMD_WRITE, 4'd0, 1'b0, '0, 1'b1, 1'b1);
		add(CMD_FIND, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_LOAD, 4'd15, 1'b1, 32'd5, 1'b0, 1'b0);
		add(CMD_LOAD, 4'd3, 1'b0, 32'h1234_5678, 1'b0, 1'b0);
		add(CMD_ERASE, 4'd15, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_SPARE_6, 4'd9, 1'b1, 32'hA5A5_5A5A, 1'b1, 1'b1);
		add(CMD_SPARE_7, 4'd6, 1'b0, 32'h5A5A_A5A5, 1'b0, 1'b1);
		add(CMD_ROLLBACK, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_LOAD, 4'd0, 1'b1, 32'd0, 1'b0, 1'b0);
		add(CMD_ROLLBACK, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_ERASE_ALL, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		drain();
		add_random(RANDOM_PER_SETTING);

		// full table, address wrap, tie on the newest edition
		set_config(16, 16'hFFFF, 1);
		add(CMD_LOAD, 4'd2, 1'b1, 32'd7, 1'b0, 1'b0);
		add(CMD_LOAD, 4'd5, 1'b1, 32'd7, 1'b0, 1'b0);
		add(CMD_FIND, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_WRITE, 4'd0, 1'b0, '0, 1'b1, 1'b0);
		add(CMD_ROLLBACK, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		add(CMD_ROLLBACK, 4'd0, 1'b0, '0, 1'b0, 1'b0);
		drain();
		add_random(RANDOM_PER_SETTING);

		set_config(4, 100, 100);
		add_random(RANDOM_PER_SETTING);
		set_config(8, 10, 11);
		add_random(RANDOM_PER_SETTING);
		set_config(0, 5, 9);
		add_random(RANDOM_PER_SETTING);
		set_config(31, 4096, 4096);
		add_random(RANDOM_PER_SETTING);
		set_config(2, 1, 65535);
		add_random(RANDOM_PER_SETTING);
		set_config(16, 65535, 65535);
		add_random(RANDOM_PER_SETTING);
		set_config(3, 16'h1234, 1);
		add_random(RANDOM_PER_SETTING);
		set_config(1, 1, 65535);
		add_random(RANDOM_PER_SETTING);
		random_setting();
		random_setting();
		drain();
		repeat (50) @(negedge clk);

		failures = mismatches + strays + due_answers.size();
		$write("covered %0d commands: %0d load, %0d write, %0d find, ", accepted,
			cmd_seen[CMD_LOAD], cmd_seen[CMD_WRITE], cmd_seen[CMD_FIND]);
		$display("%0d roll back, %0d erase, %0d erase all, %0d unused",
			cmd_seen[CMD_ROLLBACK], cmd_seen[CMD_ERASE], cmd_seen[CMD_ERASE_ALL],
			cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7]);
		$display("%0d register settings, %0d results checked, %0d mismatches, %0d stray beats",
			settings_run, answers_checked, mismatches, strays);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
src/ewl_pkg.sv
src/ewl_req_if.sv
src/ewl_rsp_if.sv
src/ewl_table.sv
src/ewl_seq.sv
src/eeprom_wear_level_slot_manager.sv
verif/tb.sv
